[rtl/assert_macros.svh]
// Assertion helpers, sampled on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge
`define UFD_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent on the following edge
`define UFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ufd_pkg.sv]
`timescale 1ns / 1ps

package ufd_pkg;

    // Special characters of the encoding
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result kinds
    localparam logic [1:0] KIND_NAME        = 2'd0;
    localparam logic [1:0] KIND_VALUE       = 2'd1;
    localparam logic [1:0] KIND_END_VALUE   = 2'd2;
    localparam logic [1:0] KIND_END_NOVALUE = 2'd3;

    // Escape digit counts
    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_ONE  = 2'd1;
    localparam logic [1:0] ESC_TWO  = 2'd2;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       bad;
        logic       str_end;
        logic       run_end;
    } result_t;

    typedef struct packed {
        logic       value_part;
        logic [1:0] digits_left;
        logic [3:0] high_nibble;
        logic       invalid;
    } dec_state_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = b - 8'h30;
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = b - 8'h37;
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = b - 8'h57;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
    endfunction

endpackage

[rtl/form_urlencoded_decoder.sv]
`timescale 1ns / 1ps

// Channel  | Dir | Signals                          | Carries
// ---------+-----+----------------------------------+---------------------------------
// input    | in  | s_tvalid s_tready s_tdata s_tlast | raw byte, last byte of string
// output   | out | m_tvalid m_tready m_tdata m_tuser | decoded byte, kind/flags,
//          |     | m_tlast                          | last result of one input byte
//
// One raw byte is taken per cycle while the input is not stalled; it waits in the input
// register and its zero to two results enter a four-entry result queue when it moves on.
// The output gives one result per cycle while m_tready is high and the queue is not empty,
// so the two results of a byte leave one after the other; the queue absorbs this and the
// input stalls only while it holds more than two results. Input ready comes from the queue
// level and the input register, both registered, with no path from m_tready.
// Reset (rst_n low, asynchronous) empties the queue and returns to the name part
// with no escape pending.
module form_urlencoded_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [1:0] kind, [2] bad_escape, [3] string_end
    output logic       m_tlast    // run_end
);

`include "assert_macros.svh"

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [7:0]                    in_byte_reg;
    logic                          in_last_reg;
    ufd_pkg::dec_state_t           state_reg;
    ufd_pkg::dec_state_t           state_next;
    logic [1:0]                    res_cnt;
    ufd_pkg::result_t              res0;
    ufd_pkg::result_t              res1;
    ufd_pkg::result_t              head;
    logic [ufd_pkg::LVL_W-1:0]     level;
    logic                          advance;
    logic                          s_accept;
    logic                          pop;
    logic [1:0]                    push_cnt;
    logic                          hold_in;
    logic                          amp_taken;

    // Handshake control
    assign advance  = in_valid_reg && (level <= ufd_pkg::LVL_W'(ufd_pkg::FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign push_cnt = advance ? res_cnt : 2'd0;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // Input register and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ufd_decode u_decode
    (
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    ufd_result_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (res0),
        .push1    (res1),
        .pop      (pop),
        .head     (head),
        .level    (level)
    );

    // Output mapping
    assign m_tvalid = (level != '0);
    assign m_tdata  = head.data;
    assign m_tuser  = {head.str_end, head.bad, head.kind};
    assign m_tlast  = head.run_end;

    // Checks
    assign hold_in   = in_valid_reg && !advance;
    assign amp_taken = advance && (in_byte_reg == ufd_pkg::CH_AMP);

    `UFD_ASSERT_NOW(a_level_bound, level <= ufd_pkg::LVL_W'(ufd_pkg::FIFO_DEPTH), "queue overflow")
    `UFD_ASSERT_NOW(a_digits_range, state_reg.digits_left != 2'd3, "escape count out of range")
    `UFD_ASSERT_NEXT(a_hold_item, hold_in, in_valid_reg && $stable(in_byte_reg), "held byte lost")
    `UFD_ASSERT_NEXT(a_pair_end_clears, amp_taken, state_reg == '0, "pair end left state behind")

endmodule

[rtl/ufd_decode.sv]
`timescale 1ns / 1ps

// One raw byte against the decoder state: next state and up to two results.
module ufd_decode
(
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  ufd_pkg::dec_state_t st,
    output ufd_pkg::dec_state_t st_next,
    output logic [1:0]          res_cnt,
    output ufd_pkg::result_t    res0,
    output ufd_pkg::result_t    res1
);

    ufd_pkg::dec_state_t st_mid;
    ufd_pkg::result_t    pre_res;
    ufd_pkg::result_t    bad_res;
    ufd_pkg::result_t    end_res;
    logic                pre_v;
    logic                fin;
    logic                fin_bad;
    logic                hex_ok;
    logic [3:0]          hv;
    logic                inv1;
    logic [3:0]          hn1;
    logic [1:0]          dl1;
    logic [7:0]          raw;

    assign hex_ok = ufd_pkg::is_hex(in_byte);
    assign hv     = ufd_pkg::hex_val(in_byte);

    // Byte classification and escape tracking
    always_comb
    begin
        st_mid  = st;
        pre_v   = 1'b0;
        fin     = 1'b0;
        inv1    = st.invalid | ~hex_ok;
        hn1     = ((st.digits_left == ufd_pkg::ESC_TWO) && hex_ok) ? hv : st.high_nibble;
        dl1     = st.digits_left - 2'd1;
        raw     = in_byte;
        pre_res = '0;
        pre_res.kind = st.value_part ? ufd_pkg::KIND_VALUE : ufd_pkg::KIND_NAME;

        if (in_byte == ufd_pkg::CH_AMP)
        begin
            fin = 1'b1;
        end
        else
        begin
            if (st.digits_left != ufd_pkg::ESC_NONE)
            begin
                if (dl1 == ufd_pkg::ESC_NONE)
                begin
                    pre_v = 1'b1;
                    if (inv1)
                    begin
                        pre_res.bad = 1'b1;
                        raw         = 8'h00;
                    end
                    else
                    begin
                        raw = {hn1, hv};
                    end
                    st_mid.digits_left = ufd_pkg::ESC_NONE;
                    st_mid.high_nibble = 4'h0;
                    st_mid.invalid     = 1'b0;
                end
                else
                begin
                    st_mid.digits_left = dl1;
                    st_mid.high_nibble = hn1;
                    st_mid.invalid     = inv1;
                end
            end
            else if (in_byte == ufd_pkg::CH_PCT)
            begin
                st_mid.digits_left = ufd_pkg::ESC_TWO;
                st_mid.high_nibble = 4'h0;
                st_mid.invalid     = 1'b0;
            end
            else if (in_byte == ufd_pkg::CH_PLUS)
            begin
                pre_v = 1'b1;
                raw   = ufd_pkg::CH_SPACE;
            end
            else if (in_byte == ufd_pkg::CH_EQ && !st.value_part)
            begin
                st_mid.value_part = 1'b1;
            end
            else
            begin
                pre_v = 1'b1;
            end
            fin = in_last;
        end

        // name bytes are lowercased, markers carry zero
        if (pre_res.bad || st.value_part)
        begin
            pre_res.data = raw;
        end
        else
        begin
            pre_res.data = ufd_pkg::to_lower(raw);
        end
    end

    // Pair close: optional dropped-escape marker, then the pair end
    always_comb
    begin
        fin_bad = fin && (st_mid.digits_left != ufd_pkg::ESC_NONE);

        bad_res      = '0;
        bad_res.kind = st_mid.value_part ? ufd_pkg::KIND_VALUE : ufd_pkg::KIND_NAME;
        bad_res.bad  = 1'b1;

        end_res         = '0;
        end_res.kind    = st_mid.value_part ? ufd_pkg::KIND_END_VALUE
                                            : ufd_pkg::KIND_END_NOVALUE;
        end_res.str_end = in_last;

        st_next = fin ? '0 : st_mid;
    end

    // Pack the present results into two slots, mark the last one
    always_comb
    begin
        res_cnt = {1'b0, pre_v} + {1'b0, fin_bad} + {1'b0, fin};
        if (pre_v)
        begin
            res0 = pre_res;
            res1 = fin_bad ? bad_res : end_res;
        end
        else if (fin_bad)
        begin
            res0 = bad_res;
            res1 = end_res;
        end
        else
        begin
            res0 = end_res;
            res1 = end_res;
        end
        res0.run_end = (res_cnt == 2'd1);
        res1.run_end = (res_cnt == 2'd2);
    end

endmodule

[rtl/ufd_result_fifo.sv]
`timescale 1ns / 1ps

// Small result queue: takes zero, one or two results a cycle, gives one.
module ufd_result_fifo
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [1:0]                  push_cnt,
    input  ufd_pkg::result_t            push0,
    input  ufd_pkg::result_t            push1,
    input  logic                        pop,
    output ufd_pkg::result_t            head,
    output logic [ufd_pkg::LVL_W-1:0]   level
);

    ufd_pkg::result_t                slot_reg [ufd_pkg::FIFO_DEPTH];
    logic [ufd_pkg::PTR_W-1:0]       wr_ptr_reg;
    logic [ufd_pkg::PTR_W-1:0]       wr_ptr_next;
    logic [ufd_pkg::PTR_W-1:0]       rd_ptr_reg;
    logic [ufd_pkg::PTR_W-1:0]       rd_ptr_next;
    logic [ufd_pkg::LVL_W-1:0]       level_reg;
    logic [ufd_pkg::LVL_W-1:0]       level_next;
    logic [ufd_pkg::PTR_W-1:0]       wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    // Pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ufd_pkg::PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + ufd_pkg::PTR_W'(pop);
        level_next  = level_reg + ufd_pkg::LVL_W'(push_cnt) - ufd_pkg::LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            slot_reg[wr_ptr_p1] <= push1;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule
